>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the route table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/rtbc_pkg.sv
package rtbc_pkg;

	// Field widths of the item and result payloads.
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned COST_W   = 16;
	localparam int unsigned PORT_W   = 4;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned ENTRY_W  = 6;
	localparam int unsigned COUNT_W  = 7;

	// Kind codes of an input item.
	localparam logic KIND_OFFER = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// Threshold register value after reset.
	localparam logic [COST_W-1:0] UNREACH_RESET = 16'hFFFF;

	// Action codes reported with every result.
	typedef enum logic [ACTION_W-1:0] {
		ACT_ADDED    = 3'd0,
		ACT_REPLACED = 3'd1,
		ACT_KEPT     = 3'd2,
		ACT_IGNORED  = 3'd3,
		ACT_FULL     = 3'd4,
		ACT_CLEARED  = 3'd5
	} rtbc_action_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] dest_addr;
		logic [ADDR_W-1:0] net_mask;
		logic [COST_W-1:0] path_cost;
		logic [ADDR_W-1:0] gateway_addr;
		logic [PORT_W-1:0] port_index;
		logic [ADDR_W-1:0] area_ident;
	} rtbc_item_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ENTRY_W-1:0]  entry_index;
		logic [COUNT_W-1:0]  route_count;
		logic                best_valid;
		logic [ENTRY_W-1:0]  best_index;
	} rtbc_result_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_APPLY
	} rtbc_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic scan_start;
		logic scan_run;
		logic commit;
	} rtbc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic skip_scan;
		logic hit;
		logic exhausted;
	} rtbc_sts_t;

endpackage

>>> hw/rtl/rtbc_if.sv
// Input item channel.
interface rtbc_item_if import rtbc_pkg::*; ();
	logic       valid;
	logic       ready;
	rtbc_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface rtbc_result_if import rtbc_pkg::*; ();
	logic         valid;
	logic         ready;
	rtbc_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel for the unreachable cost threshold.
interface rtbc_cfg_if import rtbc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/rtbc_dpath.sv
`include "assert_macros.svh"

module rtbc_dpath import rtbc_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtbc_item_t        item_data,
	input  logic              cfg_we,
	input  logic [COST_W-1:0] cfg_data,
	input  rtbc_cmd_t         cmd,
	output rtbc_sts_t         sts,
	output rtbc_result_t      res
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	// Route fields that are stored but never searched.
	typedef struct packed {
		logic [ADDR_W-1:0] net_mask;
		logic [ADDR_W-1:0] gateway_addr;
		logic [PORT_W-1:0] port_index;
		logic [ADDR_W-1:0] area_ident;
	} route_row_t;

	rtbc_item_t        item_q;
	logic [COST_W-1:0] unreach_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [COST_W-1:0] best_cost_q;
	logic [ADDR_W-1:0] best_area_q;

	logic [ADDR_W-1:0] dest_mem  [TABLE_DEPTH];
	logic [COST_W-1:0] cost_mem  [TABLE_DEPTH];
	route_row_t        route_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]  issue_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [ADDR_W-1:0] dest_rd_s1;
	logic [COST_W-1:0] cost_rd_s1;

	logic              found_q;
	logic [IDX_W-1:0]  slot_q;
	logic [COST_W-1:0] match_cost_q;

	rtbc_result_t      res_q;

	logic              ignored;
	logic              issue_ok;
	logic              hit;
	logic              do_issue;

	rtbc_action_t      act;
	logic [IDX_W-1:0]  slot;
	logic              mem_we;
	logic [CNT_W-1:0]  nx_count;
	logic [IDX_W-1:0]  nx_best_idx;
	logic [COST_W-1:0] nx_best_cost;
	logic [ADDR_W-1:0] nx_best_area;
	logic              is_full;
	logic              better_new;
	logic              tie_new;
	rtbc_result_t      res_d;

	// Offer item and threshold registers.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unreach_q <= UNREACH_RESET;
		end else if (cfg_we) begin
			unreach_q <= cfg_data;
		end
	end

	// Search status.
	assign ignored  = (item_q.net_mask == '0) || (item_q.path_cost >= unreach_q);
	assign issue_ok = issue_q < count_q;
	assign hit      = rd_vld_s1 && (dest_rd_s1 == item_q.dest_addr);
	assign do_issue = cmd.scan_run && !hit && issue_ok;

	assign sts.skip_scan = (item_q.kind == KIND_CLEAR) || ignored;
	assign sts.hit       = hit;
	assign sts.exhausted = !rd_vld_s1 && !issue_ok;

	// Scan address counter and read-valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= do_issue;
			if (cmd.scan_start) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (do_issue) begin
					issue_q <= issue_q + 1'b1;
				end
				if (cmd.scan_run && hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Matched slot and its stored cost.
	always_ff @(posedge clk) begin
		if (do_issue) begin
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (cmd.scan_run && hit) begin
			slot_q       <= rd_idx_s1;
			match_cost_q <= cost_rd_s1;
		end
	end

	// Table memories: one write port at commit, one registered read port for the search.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dest_mem[slot] <= item_q.dest_addr;
		end
		if (do_issue) begin
			dest_rd_s1 <= dest_mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cost_mem[slot] <= item_q.path_cost;
		end
		if (do_issue) begin
			cost_rd_s1 <= cost_mem[issue_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			route_mem[slot] <= '{
				net_mask:     item_q.net_mask,
				gateway_addr: item_q.gateway_addr,
				port_index:   item_q.port_index,
				area_ident:   item_q.area_ident
			};
		end
	end

	// Decide the action and the new table summary for the current item.
	assign is_full    = count_q == CNT_W'(TABLE_DEPTH);
	assign better_new = (item_q.path_cost < best_cost_q) ||
		((item_q.path_cost == best_cost_q) && (item_q.area_ident > best_area_q));
	assign tie_new    = (item_q.path_cost == best_cost_q) &&
		(item_q.area_ident == best_area_q);

	always_comb begin
		act          = ACT_IGNORED;
		slot         = '0;
		mem_we       = 1'b0;
		nx_count     = count_q;
		nx_best_idx  = best_idx_q;
		nx_best_cost = best_cost_q;
		nx_best_area = best_area_q;
		priority if (item_q.kind == KIND_CLEAR) begin
			act      = ACT_CLEARED;
			nx_count = '0;
		end else if (ignored) begin
			act = ACT_IGNORED;
		end else if (found_q) begin
			slot = slot_q;
			if (item_q.path_cost < match_cost_q) begin
				act    = ACT_REPLACED;
				mem_we = cmd.commit;
				// A lowered cost can only move the best route onto this slot.
				if ((slot_q == best_idx_q) || better_new ||
					(tie_new && (slot_q < best_idx_q))) begin
					nx_best_idx  = slot_q;
					nx_best_cost = item_q.path_cost;
					nx_best_area = item_q.area_ident;
				end
			end else begin
				act = ACT_KEPT;
			end
		end else if (is_full) begin
			act = ACT_FULL;
		end else begin
			act      = ACT_ADDED;
			slot     = count_q[IDX_W-1:0];
			mem_we   = cmd.commit;
			nx_count = count_q + 1'b1;
			// The appended slot is last in scan order, so ties keep the older best.
			if ((count_q == '0) || better_new) begin
				nx_best_idx  = count_q[IDX_W-1:0];
				nx_best_cost = item_q.path_cost;
				nx_best_area = item_q.area_ident;
			end
		end
	end

	always_comb begin
		res_d.action      = act;
		res_d.entry_index = ENTRY_W'(slot);
		res_d.route_count = COUNT_W'(nx_count);
		res_d.best_valid  = nx_count != '0;
		res_d.best_index  = (nx_count != '0) ? ENTRY_W'(nx_best_idx) : '0;
	end

	// Table summary registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= nx_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			best_idx_q  <= nx_best_idx;
			best_cost_q <= nx_best_cost;
			best_area_q <= nx_best_area;
			res_q       <= res_d;
		end
	end

	assign res = res_q;

	`RTBC_ASSERT_NXT(a_add_counts, clk, arst_n, cmd.commit && (act == ACT_ADDED), count_q == CNT_W'($past(count_q) + 1'b1), "add did not increment the route count")
	`RTBC_ASSERT_IMP(a_read_in_range, clk, arst_n, rd_vld_s1, CNT_W'(rd_idx_s1) < count_q, "search read beyond the valid routes")
	`RTBC_ASSERT_IMP(a_best_in_range, clk, arst_n, count_q != '0, CNT_W'(best_idx_q) < count_q, "best route slot beyond the valid routes")

endmodule

>>> hw/rtl/rtbc_ctrl.sv
`include "assert_macros.svh"

module rtbc_ctrl import rtbc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	output logic      result_valid,
	input  logic      result_ready,
	input  rtbc_sts_t sts,
	output rtbc_cmd_t cmd
);

	rtbc_state_t state_q;
	rtbc_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	// The output register can take a new result once its current one is taken.
	assign out_free = !out_valid_q || result_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.skip_scan ? ST_APPLY : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.hit || sts.exhausted) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready    = 1'b1;
				cmd.load_item = item_valid;
			end
			ST_CHECK: begin
				cmd.scan_start = !sts.skip_scan;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
			end
			ST_APPLY: begin
				cmd.commit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

	`RTBC_ASSERT_NXT(a_scan_ends, clk, arst_n, (state_q == ST_SCAN) && (sts.hit || sts.exhausted), state_q == ST_APPLY, "search end did not lead to the update")

endmodule

>>> hw/rtl/route_table_best_cost_update.sv
// Route table with lowest-cost update. Each accepted item on the item channel
// yields exactly one transaction on the result channel. A clear item, or an
// offer that is ignored (zero mask, or cost at or above the unreachable cost
// register), skips the search and goes from the check straight to the update.
// Any other offer searches the table by destination one slot per cycle through
// the single read port of the table memory. A match ends the search at its
// slot; a miss reads all N routes held, none when the table is empty, so at
// most TABLE_DEPTH slots. The result is written only once the output register
// is free, so it waits while the previous result still waits there. The next
// item is accepted in the cycle after the result is written, so one item is
// worked on at a time while the previous result may still wait in the output
// register. The least-cost route is kept in registers and updated with each
// write, so it costs no extra scan. The table needs no clearing pass after
// reset. The threshold register may be written at any time the block is idle
// and is taken at once.
module route_table_best_cost_update import rtbc_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 64
) (
	input logic            clk,
	input logic            arst_n,
	rtbc_item_if.sink      item,
	rtbc_result_if.source  result,
	rtbc_cfg_if.sink       cfg
);

	rtbc_cmd_t cmd;
	rtbc_sts_t sts;

	// The threshold register is always free to take a write.
	assign cfg.ready = 1'b1;

	rtbc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	rtbc_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_data (item.data),
		.cfg_we    (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.sts       (sts),
		.res       (result.data)
	);

endmodule
